/* rtl/im2col_sag_pkg.sv */
package im2col_sag_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned IMAGE_W   = 8;
  localparam int unsigned POS_W     = 12;
  localparam int unsigned CHAN_W    = 10;
  localparam int unsigned KER_W     = 6;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned OFFSET_W  = 17;
  localparam int unsigned INDEX_W   = 42;

  // Configuration port shape.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 17;

  // Internal datapath widths.
  localparam int unsigned SPAN_W  = POS_W + STEP_W;        // out_y * stride
  localparam int unsigned COORD_W = SPAN_W + 2;            // signed source row or column
  localparam int unsigned PLANE_W = IMAGE_W + COUNT_W;     // image * channel_count + channel
  localparam int unsigned ROWS_W  = PLANE_W + DIM_W;       // plane * in_height + row
  localparam int unsigned FULL_W  = ROWS_W + DIM_W;        // full product before wrapping

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IN_HEIGHT     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IN_WIDTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_ROWS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE_COLS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_ROWS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_COLS   = 3'd6;

  typedef struct packed {
    logic [IMAGE_W-1:0] image;
    logic [POS_W-1:0]   out_y;
    logic [POS_W-1:0]   out_x;
    logic [CHAN_W-1:0]  channel;
    logic [KER_W-1:0]   ky;
    logic [KER_W-1:0]   kx;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] source_index;
    logic               is_pad;
  } out_word_t;

  typedef struct packed {
    logic [COUNT_W-1:0]         channel_count;
    logic [DIM_W-1:0]           in_height;
    logic [DIM_W-1:0]           in_width;
    logic [STEP_W-1:0]          stride_rows;
    logic [STEP_W-1:0]          stride_cols;
    logic signed [OFFSET_W-1:0] offset_rows;
    logic signed [OFFSET_W-1:0] offset_cols;
  } cfg_regs_t;

endpackage

/* rtl/im2col_sag_cfg.sv */
module im2col_sag_cfg (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     cfg_we,
  input  logic [im2col_sag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [im2col_sag_pkg::CFG_DATA_W-1:0]    cfg_data,
  output im2col_sag_pkg::cfg_regs_t                regs_o
);

  im2col_sag_pkg::cfg_regs_t regs_r;
  im2col_sag_pkg::cfg_regs_t regs_nxt;

  // Decode a write onto the addressed register; unknown indexes are dropped.
  always_comb begin
    regs_nxt = regs_r;
    if (cfg_we) begin
      unique case (cfg_index)
        im2col_sag_pkg::REG_CHANNEL_COUNT:
          regs_nxt.channel_count = cfg_data[im2col_sag_pkg::COUNT_W-1:0];
        im2col_sag_pkg::REG_IN_HEIGHT:
          regs_nxt.in_height = cfg_data[im2col_sag_pkg::DIM_W-1:0];
        im2col_sag_pkg::REG_IN_WIDTH:
          regs_nxt.in_width = cfg_data[im2col_sag_pkg::DIM_W-1:0];
        im2col_sag_pkg::REG_STRIDE_ROWS:
          regs_nxt.stride_rows = cfg_data[im2col_sag_pkg::STEP_W-1:0];
        im2col_sag_pkg::REG_STRIDE_COLS:
          regs_nxt.stride_cols = cfg_data[im2col_sag_pkg::STEP_W-1:0];
        im2col_sag_pkg::REG_OFFSET_ROWS:
          regs_nxt.offset_rows = $signed(cfg_data[im2col_sag_pkg::OFFSET_W-1:0]);
        im2col_sag_pkg::REG_OFFSET_COLS:
          regs_nxt.offset_cols = $signed(cfg_data[im2col_sag_pkg::OFFSET_W-1:0]);
        default: begin
        end
      endcase
    end
  end

  // Register file with its reset values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.channel_count <= im2col_sag_pkg::COUNT_W'(1);
      regs_r.in_height     <= im2col_sag_pkg::DIM_W'(1);
      regs_r.in_width      <= im2col_sag_pkg::DIM_W'(1);
      regs_r.stride_rows   <= im2col_sag_pkg::STEP_W'(1);
      regs_r.stride_cols   <= im2col_sag_pkg::STEP_W'(1);
      regs_r.offset_rows   <= '0;
      regs_r.offset_cols   <= '0;
    end else begin
      regs_r <= regs_nxt;
    end
  end

  assign regs_o = regs_r;

endmodule

/* rtl/im2col_source_address_gen_top.sv */
// im2col source address generator. Each input word names one patch element
// (image, output row and column, channel, kernel row and column) and yields one
// output word: the flat NCHW index of the input element to read, or a pad flag
// with index zero when the source position falls outside the input plane. The
// datapath is a six-stage pipeline (stride products, source coordinates and
// plane base, bounds check and height product, row add, width product, column
// add), so one word is accepted every cycle while the output side does not
// stall. A stall holds each stage that holds a word and lets empty stages
// fill first. Configuration registers are read straight into the
// pipeline and must only be written while no word is in flight.
module im2col_source_address_gen_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  im2col_sag_pkg::in_word_t              in_data,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output im2col_sag_pkg::out_word_t             out_data,
  input  logic                                  cfg_we,
  input  logic [im2col_sag_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [im2col_sag_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned SPAN_W  = im2col_sag_pkg::SPAN_W;
  localparam int unsigned COORD_W = im2col_sag_pkg::COORD_W;
  localparam int unsigned PLANE_W = im2col_sag_pkg::PLANE_W;
  localparam int unsigned ROWS_W  = im2col_sag_pkg::ROWS_W;
  localparam int unsigned FULL_W  = im2col_sag_pkg::FULL_W;
  localparam int unsigned DIM_W   = im2col_sag_pkg::DIM_W;
  localparam int unsigned INDEX_W = im2col_sag_pkg::INDEX_W;
  localparam int unsigned CHAN_W  = im2col_sag_pkg::CHAN_W;
  localparam int unsigned KER_W   = im2col_sag_pkg::KER_W;
  localparam int unsigned OFFSET_W = im2col_sag_pkg::OFFSET_W;

  im2col_sag_pkg::cfg_regs_t regs;

  im2col_sag_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs_o    (regs)
  );

  // Stage valids and advance enables; a stage moves when it is empty or the
  // stage after it moves.
  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic en1, en2, en3, en4, en5, en6;

  always_comb begin
    en6 = !out_valid_r || !out_stall;
    en5 = !v5_r || en6;
    en4 = !v4_r || en5;
    en3 = !v3_r || en4;
    en2 = !v2_r || en3;
    en1 = !v1_r || en2;
  end

  assign in_stall  = !en1;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
      if (en6) out_valid_r <= v5_r;
    end
  end

  // Stage 1: stride products and image plane product.
  logic [SPAN_W-1:0]  span_y_r, span_y_nxt, span_x_r, span_x_nxt;
  logic [PLANE_W-1:0] img_r, img_nxt;
  logic [CHAN_W-1:0]  chan1_r;
  logic [KER_W-1:0]   ky1_r, kx1_r;

  always_comb begin
    span_y_nxt = SPAN_W'(in_data.out_y * regs.stride_rows);
    span_x_nxt = SPAN_W'(in_data.out_x * regs.stride_cols);
    img_nxt    = PLANE_W'(in_data.image * regs.channel_count);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      span_y_r <= span_y_nxt;
      span_x_r <= span_x_nxt;
      img_r    <= img_nxt;
      chan1_r  <= in_data.channel;
      ky1_r    <= in_data.ky;
      kx1_r    <= in_data.kx;
    end
  end

  // Stage 2: signed source coordinates and channel plane number.
  logic signed [COORD_W-1:0] row_r, row_nxt, col_r, col_nxt;
  logic [PLANE_W-1:0]        plane_r, plane_nxt;

  always_comb begin
    row_nxt = $signed({2'b00, span_y_r}) + $signed({{(COORD_W-KER_W){1'b0}}, ky1_r})
            + $signed({{(COORD_W-OFFSET_W){regs.offset_rows[OFFSET_W-1]}},
                       regs.offset_rows});
    col_nxt = $signed({2'b00, span_x_r}) + $signed({{(COORD_W-KER_W){1'b0}}, kx1_r})
            + $signed({{(COORD_W-OFFSET_W){regs.offset_cols[OFFSET_W-1]}},
                       regs.offset_cols});
    plane_nxt = img_r + {{(PLANE_W-CHAN_W){1'b0}}, chan1_r};
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      plane_r <= plane_nxt;
    end
  end

  // Stage 3: bounds check and height product.
  logic              inside3_r, inside3_nxt;
  logic [ROWS_W-1:0] base3_r, base3_nxt;
  logic [DIM_W-1:0]  row3_r, col3_r;

  always_comb begin
    inside3_nxt = !row_r[COORD_W-1]
               && (row_r[COORD_W-2:0] < {{(COORD_W-1-DIM_W){1'b0}}, regs.in_height})
               && !col_r[COORD_W-1]
               && (col_r[COORD_W-2:0] < {{(COORD_W-1-DIM_W){1'b0}}, regs.in_width});
    base3_nxt = ROWS_W'(plane_r * regs.in_height);
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      inside3_r <= inside3_nxt;
      base3_r   <= base3_nxt;
      row3_r    <= row_r[DIM_W-1:0];
      col3_r    <= col_r[DIM_W-1:0];
    end
  end

  // Stage 4: add the source row; inside the plane it is below in_height.
  logic              inside4_r;
  logic [ROWS_W-1:0] rows4_r, rows4_nxt;
  logic [DIM_W-1:0]  col4_r;

  assign rows4_nxt = base3_r + {{(ROWS_W-DIM_W){1'b0}}, row3_r};

  always_ff @(posedge clk) begin
    if (en4) begin
      inside4_r <= inside3_r;
      rows4_r   <= rows4_nxt;
      col4_r    <= col3_r;
    end
  end

  // Stage 5: width product, wrapped to the index width.
  logic               inside5_r;
  logic [FULL_W-1:0]  full5_nxt;
  logic [INDEX_W-1:0] lin5_r;
  logic [DIM_W-1:0]   col5_r;

  assign full5_nxt = rows4_r * regs.in_width;

  always_ff @(posedge clk) begin
    if (en5) begin
      inside5_r <= inside4_r;
      lin5_r    <= full5_nxt[INDEX_W-1:0];
      col5_r    <= col4_r;
    end
  end

  // Stage 6: add the source column and form the output word.
  im2col_sag_pkg::out_word_t out_r, out_nxt;

  always_comb begin
    if (inside5_r) begin
      out_nxt.source_index = lin5_r + {{(INDEX_W-DIM_W){1'b0}}, col5_r};
      out_nxt.is_pad       = 1'b0;
    end else begin
      out_nxt.source_index = '0;
      out_nxt.is_pad       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en6) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/im2col_sag_chk.sv */
module im2col_sag_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input im2col_sag_pkg::out_word_t out_data
);

  // A padded word always carries a zero index.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_pad |-> out_data.source_index == '0)
    else $error("padded word with non-zero index");

  // With the output side free, the whole pipeline moves and takes a word.
  a_no_stall_through: assert property (@(posedge clk) disable iff (!rst_n)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output side is free");

  // Nothing is presented right after reset.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid straight after reset");

  // A stalled output word stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output word changed");

endmodule

bind im2col_source_address_gen_top im2col_sag_chk u_im2col_sag_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
